FILE: rtl/dqbrx_pkg.sv
// Shared constants and types for the two-query blocked row XOR block.
package dqbrx_pkg;

   // Word and position widths
   localparam int WORD_BITS = 32;
   localparam int COLS_MAX  = 1024;
   localparam int ROWS_MAX  = 65536;
   localparam int COL_W     = $clog2(COLS_MAX);
   localparam int COL_CNT_W = COL_W + 1;
   localparam int ROW_W     = $clog2(ROWS_MAX);
   localparam int ROW_CNT_W = ROW_W + 1;
   localparam int CSR_W     = ROW_CNT_W;
   localparam int CSR_IDX_W = 2;
   localparam int OUTQ_DEPTH = 3;

   // Register reset values
   localparam logic [COL_CNT_W-1:0] COLUMN_COUNT_RST = COL_CNT_W'(COLS_MAX);
   localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST    = ROW_CNT_W'(ROWS_MAX);
   localparam logic [ROW_CNT_W-1:0] BLOCK_ROWS_RST   = ROW_CNT_W'(1024);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_ROWS   = 2'd2;

   // One finished column sum pair
   typedef struct packed {
      logic [ROW_W-1:0]     block_number;
      logic [COL_W-1:0]     column_number;
      logic [WORD_BITS-1:0] sum_a;
      logic [WORD_BITS-1:0] sum_b;
      logic                 last;
   } rsp_item_type;

   // Clamp a column count into 1..COLS_MAX
   function automatic logic [COL_CNT_W-1:0] clamp_cols(input logic [COL_CNT_W-1:0] v);
      logic [COL_CNT_W-1:0] r;
      r = v;
      if (v == '0) r = COL_CNT_W'(1);
      else if (v > COL_CNT_W'(COLS_MAX)) r = COL_CNT_W'(COLS_MAX);
      return r;
   endfunction

   // Clamp a row count into 1..ROWS_MAX
   function automatic logic [ROW_CNT_W-1:0] clamp_rows(input logic [ROW_CNT_W-1:0] v);
      logic [ROW_CNT_W-1:0] r;
      r = v;
      if (v == '0) r = ROW_CNT_W'(1);
      else if (v > ROW_CNT_W'(ROWS_MAX)) r = ROW_CNT_W'(ROWS_MAX);
      return r;
   endfunction

endpackage

FILE: rtl/dual_query_blocked_row_xor.sv
// Top level: two-query blocked GF(2) row accumulation over a streamed matrix.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | matrix_word, select_a, select_b
//  rsp     | out       | rsp_valid / rsp_ready  | block_number, column_number, sum_a, sum_b, last
//  csr     | in        | csr_write_en           | csr_index, csr_wdata
//
// One request per cycle while req_ready is high; an accepted request in a block's last row
// pushes its column's sums into the output queue from the write-back stage (accumulator read at
// accept, XOR and write-back in the cycle after). Back-to-back requests to the same column are
// forwarded around the memory. Synchronous reset clears positions and the queue and loads the
// registers' reset values; the accumulators need none. A three-entry output queue absorbs
// stalls on rsp; req_ready drops while the queue and the write-back stage together hold three sums.
module dual_query_blocked_row_xor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dqbrx_pkg::WORD_BITS-1:0]      req_matrix_word,
   input  logic                                 req_select_a,
   input  logic                                 req_select_b,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dqbrx_pkg::ROW_W-1:0]          rsp_block_number,
   output logic [dqbrx_pkg::COL_W-1:0]          rsp_column_number,
   output logic [dqbrx_pkg::WORD_BITS-1:0]      rsp_sum_a,
   output logic [dqbrx_pkg::WORD_BITS-1:0]      rsp_sum_b,
   output logic                                 rsp_last,
   input  logic                                 csr_write_en,
   input  logic [dqbrx_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dqbrx_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int W  = dqbrx_pkg::WORD_BITS;
   localparam int CW = dqbrx_pkg::COL_W;
   localparam int CC = dqbrx_pkg::COL_CNT_W;
   localparam int RW = dqbrx_pkg::ROW_W;
   localparam int RC = dqbrx_pkg::ROW_CNT_W;

   // Configuration registers
   logic [CC-1:0] column_count_ff;
   logic [RC-1:0] row_count_ff;
   logic [RC-1:0] block_rows_ff;

   // Stream positions
   logic [CW-1:0] column_pos_ff, column_pos_in;
   logic [RW-1:0] row_pos_ff, row_pos_in;
   logic [RW-1:0] row_in_block_ff, row_in_block_in;
   logic [RW-1:0] block_pos_ff, block_pos_in;

   // Accumulator memories
   logic [W-1:0] accum_a_mem [dqbrx_pkg::COLS_MAX];
   logic [W-1:0] accum_b_mem [dqbrx_pkg::COLS_MAX];
   logic [W-1:0] rd_a_ff, rd_b_ff;

   // Write-back stage
   logic          s1_valid_ff;
   logic [CW-1:0] s1_col_ff;
   logic          s1_first_ff;
   logic          s1_sel_a_ff, s1_sel_b_ff;
   logic [W-1:0]  s1_word_ff;
   logic          s1_emit_ff;
   logic          s1_last_ff;
   logic [RW-1:0] s1_block_ff;
   logic          fwd_ff;
   logic [W-1:0]  fwd_a_ff, fwd_b_ff;
   logic [W-1:0]  new_a, new_b, old_a, old_b;

   // Output queue
   dqbrx_pkg::rsp_item_type outq_ff [dqbrx_pkg::OUTQ_DEPTH];
   logic [1:0] outq_count_ff, outq_wr_ff, outq_rd_ff;
   logic       push, pop;
   dqbrx_pkg::rsp_item_type head, push_item;

   // Per-request decode
   logic          accept;
   logic [CC-1:0] cols_eff;
   logic [RC-1:0] rows_eff, blk_eff;
   logic          first_row, row_end, matrix_end_row, block_end_row;

   assign accept   = req_valid && req_ready;
   assign cols_eff = dqbrx_pkg::clamp_cols(column_count_ff);
   assign rows_eff = dqbrx_pkg::clamp_rows(row_count_ff);
   assign blk_eff  = dqbrx_pkg::clamp_rows(block_rows_ff);

   assign first_row      = (row_in_block_ff == '0);
   assign row_end        = ({1'b0, column_pos_ff} + CC'(1)) >= cols_eff;
   assign matrix_end_row = ({1'b0, row_pos_ff} + RC'(1)) >= rows_eff;
   assign block_end_row  = matrix_end_row || (({1'b0, row_in_block_ff} + RC'(1)) >= blk_eff);

   // Room for the request in flight plus one more
   assign req_ready = (3'(outq_count_ff) + 3'(s1_valid_ff && s1_emit_ff)) <= 3'd2;

   // Advance positions
   always_comb begin
      column_pos_in   = column_pos_ff;
      row_pos_in      = row_pos_ff;
      row_in_block_in = row_in_block_ff;
      block_pos_in    = block_pos_ff;
      if (!row_end) begin
         column_pos_in = column_pos_ff + CW'(1);
      end else begin
         column_pos_in = '0;
         if (matrix_end_row) begin
            row_pos_in      = '0;
            row_in_block_in = '0;
            block_pos_in    = '0;
         end else begin
            row_pos_in = row_pos_ff + RW'(1);
            if (block_end_row) begin
               row_in_block_in = '0;
               block_pos_in    = block_pos_ff + RW'(1);
            end else begin
               row_in_block_in = row_in_block_ff + RW'(1);
            end
         end
      end
   end

   // Hold configuration and positions
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= dqbrx_pkg::COLUMN_COUNT_RST;
         row_count_ff    <= dqbrx_pkg::ROW_COUNT_RST;
         block_rows_ff   <= dqbrx_pkg::BLOCK_ROWS_RST;
         column_pos_ff   <= '0;
         row_pos_ff      <= '0;
         row_in_block_ff <= '0;
         block_pos_ff    <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               dqbrx_pkg::CSR_COLUMN_COUNT: column_count_ff <= csr_wdata[CC-1:0];
               dqbrx_pkg::CSR_ROW_COUNT:    row_count_ff    <= csr_wdata;
               dqbrx_pkg::CSR_BLOCK_ROWS:   block_rows_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            column_pos_ff   <= column_pos_in;
            row_pos_ff      <= row_pos_in;
            row_in_block_ff <= row_in_block_in;
            block_pos_ff    <= block_pos_in;
         end
      end
   end

   // Read on accept, write back in the cycle after
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         accum_a_mem[s1_col_ff] <= new_a;
         accum_b_mem[s1_col_ff] <= new_b;
      end
      if (accept) begin
         rd_a_ff <= accum_a_mem[column_pos_ff];
         rd_b_ff <= accum_b_mem[column_pos_ff];
      end
   end

   // Capture the write-back stage and forward a same-column write
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         fwd_ff      <= accept && s1_valid_ff && (s1_col_ff == column_pos_ff);
      end
      fwd_a_ff <= new_a;
      fwd_b_ff <= new_b;
      if (accept) begin
         s1_col_ff   <= column_pos_ff;
         s1_first_ff <= first_row;
         s1_sel_a_ff <= req_select_a;
         s1_sel_b_ff <= req_select_b;
         s1_word_ff  <= req_matrix_word;
         s1_emit_ff  <= block_end_row;
         s1_last_ff  <= matrix_end_row && row_end;
         s1_block_ff <= block_pos_ff;
      end
   end

   // Load on a block's first row, XOR in otherwise
   always_comb begin
      old_a = fwd_ff ? fwd_a_ff : rd_a_ff;
      old_b = fwd_ff ? fwd_b_ff : rd_b_ff;
      if (s1_first_ff) begin
         old_a = '0;
         old_b = '0;
      end
      new_a = old_a ^ (s1_sel_a_ff ? s1_word_ff : '0);
      new_b = old_b ^ (s1_sel_b_ff ? s1_word_ff : '0);
   end

   // Queue finished sums
   assign push = s1_valid_ff && s1_emit_ff;
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      push_item.block_number  = s1_block_ff;
      push_item.column_number = s1_col_ff;
      push_item.sum_a         = new_a;
      push_item.sum_b         = new_b;
      push_item.last          = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outq_count_ff <= '0;
         outq_wr_ff    <= '0;
         outq_rd_ff    <= '0;
      end else begin
         if (push) begin
            outq_wr_ff <= (outq_wr_ff == 2'(dqbrx_pkg::OUTQ_DEPTH - 1)) ? '0 : outq_wr_ff + 2'd1;
         end
         if (pop) begin
            outq_rd_ff <= (outq_rd_ff == 2'(dqbrx_pkg::OUTQ_DEPTH - 1)) ? '0 : outq_rd_ff + 2'd1;
         end
         outq_count_ff <= outq_count_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         outq_ff[outq_wr_ff] <= push_item;
      end
   end

   assign head              = outq_ff[outq_rd_ff];
   assign rsp_valid         = (outq_count_ff != '0);
   assign rsp_block_number  = head.block_number;
   assign rsp_column_number = head.column_number;
   assign rsp_sum_a         = head.sum_a;
   assign rsp_sum_b         = head.sum_b;
   assign rsp_last          = head.last;

   // Queue never overflows
   assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (outq_count_ff == 2'(dqbrx_pkg::OUTQ_DEPTH))))
      else $error("output queue overflow");

   // Forwarding only feeds a live write-back
   assert property (@(posedge clock) disable iff (reset) fwd_ff |-> s1_valid_ff)
      else $error("forward without write-back");

   // The matrix's final word returns all positions to zero
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff) |-> (column_pos_ff == '0 && row_pos_ff == '0
                                       && row_in_block_ff == '0 && block_pos_ff == '0))
      else $error("positions not cleared after matrix end");

endmodule
